### hw/rtl/kplock_pkg.sv
// ----------------------------------------------------------------------------
// kplock_pkg
// Shared types and constants of the keypad password lock.
// ----------------------------------------------------------------------------
package kplock_pkg;

    localparam int CODE_LEN_DEF = 20;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int LEN_OUT_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FAIL  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_FAIL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_WAIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_FAIL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_WAIT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FAIL  = 3'd6;

    localparam logic [7:0] RST_FIRST_FAIL  = 8'd3;
    localparam logic [7:0] RST_FIRST_WAIT  = 8'd30;
    localparam logic [7:0] RST_SECOND_FAIL = 8'd5;
    localparam logic [7:0] RST_SECOND_WAIT = 8'd60;
    localparam logic [7:0] RST_THIRD_FAIL  = 8'd10;
    localparam logic [7:0] RST_THIRD_WAIT  = 8'd120;
    localparam logic [7:0] RST_BLOCK_FAIL  = 8'd15;

    localparam logic [7:0] KEY_CLEAR = 8'h08;
    localparam logic [7:0] KEY_END   = 8'h00;
    localparam logic [7:0] FAIL_MAX  = 8'hFF;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_TAKEN   = 3'd1,
        EV_CLEARED = 3'd2,
        EV_SAVED   = 3'd3,
        EV_CORRECT = 3'd4,
        EV_INVALID = 3'd5,
        EV_BLOCKED = 3'd6
    } event_t;

    typedef struct packed {
        logic [7:0] first_fail_count;
        logic [7:0] first_wait;
        logic [7:0] second_fail_count;
        logic [7:0] second_wait;
        logic [7:0] third_fail_count;
        logic [7:0] third_wait;
        logic [7:0] block_fail_count;
    } cfg_t;

    typedef struct packed {
        logic                 relay_open;
        logic                 locked_out;
        logic [7:0]           wait_seconds;
        logic                 setup_mode;
        logic [LEN_OUT_W-1:0] entry_length;
        event_t               event_res;
    } result_t;

endpackage

### hw/rtl/kplock_if.sv
// ----------------------------------------------------------------------------
// kplock_if
// Valid/ready channels of the keypad password lock.
// ----------------------------------------------------------------------------
interface kplock_key_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [7:0] key_code;

    modport source (output valid, output func, output key_code, input ready);
    modport sink (input valid, input func, input key_code, output ready);
endinterface

interface kplock_res_if;
    logic       valid;
    logic       ready;
    logic       relay_open;
    logic       locked_out;
    logic [7:0] wait_seconds;
    logic       setup_mode;
    logic [4:0] entry_length;
    logic [2:0] event_res;

    modport source (output valid, output relay_open, output locked_out,
                    output wait_seconds, output setup_mode, output entry_length,
                    output event_res, input ready);
    modport sink (input valid, input relay_open, input locked_out,
                  input wait_seconds, input setup_mode, input entry_length,
                  input event_res, output ready);
endinterface

interface kplock_cfg_if;
    logic       valid;
    logic       ready;
    logic [2:0] index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/keypad_password_lock.sv
// ----------------------------------------------------------------------------
// keypad_password_lock
// Keypad code lock with fail counting, timed waits and permanent lockout.
// ----------------------------------------------------------------------------
// Every accepted word (a key or a one-second tick) yields one result word,
// registered at acceptance; a new word is accepted every clock
// as long as the result side keeps up. The stored code lives in a CODE_LEN
// deep memory whose registered read is prefetched at the next entry index,
// so the per-key compare needs no separate memory read. Configuration is written
// through the cfg channel, which is always ready; indexes past the last
// register are ignored.
module keypad_password_lock #(
    parameter int CODE_LEN = kplock_pkg::CODE_LEN_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    kplock_key_if.sink   key_in,
    kplock_res_if.source res_out,
    kplock_cfg_if.sink   cfg
);
    import kplock_pkg::*;

    cfg_t    cfg_val;
    result_t res;

    assign cfg.ready = 1'b1;

    kplock_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_val)
    );

    kplock_core #(
        .CODE_LEN (CODE_LEN)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_val),
        .in_valid  (key_in.valid),
        .in_ready  (key_in.ready),
        .in_func   (key_in.func),
        .in_key    (key_in.key_code),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .out_res   (res)
    );

    assign res_out.relay_open   = res.relay_open;
    assign res_out.locked_out   = res.locked_out;
    assign res_out.wait_seconds = res.wait_seconds;
    assign res_out.setup_mode   = res.setup_mode;
    assign res_out.entry_length = res.entry_length;
    assign res_out.event_res    = res.event_res;

endmodule

### hw/rtl/kplock_cfg.sv
// ----------------------------------------------------------------------------
// kplock_cfg
// Configuration register file: fail thresholds and wait lengths.
// ----------------------------------------------------------------------------
module kplock_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [kplock_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [kplock_pkg::CFG_DATA_W-1:0]    wr_data,
    output kplock_pkg::cfg_t                     cfg
);
    import kplock_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.first_fail_count  <= RST_FIRST_FAIL;
            cfg_reg.first_wait        <= RST_FIRST_WAIT;
            cfg_reg.second_fail_count <= RST_SECOND_FAIL;
            cfg_reg.second_wait       <= RST_SECOND_WAIT;
            cfg_reg.third_fail_count  <= RST_THIRD_FAIL;
            cfg_reg.third_wait        <= RST_THIRD_WAIT;
            cfg_reg.block_fail_count  <= RST_BLOCK_FAIL;
        end
        else if (wr_en)
        begin
            case (wr_index)
                CFG_FIRST_FAIL:  cfg_reg.first_fail_count  <= wr_data;
                CFG_FIRST_WAIT:  cfg_reg.first_wait        <= wr_data;
                CFG_SECOND_FAIL: cfg_reg.second_fail_count <= wr_data;
                CFG_SECOND_WAIT: cfg_reg.second_wait       <= wr_data;
                CFG_THIRD_FAIL:  cfg_reg.third_fail_count  <= wr_data;
                CFG_THIRD_WAIT:  cfg_reg.third_wait        <= wr_data;
                CFG_BLOCK_FAIL:  cfg_reg.block_fail_count  <= wr_data;
                default:         ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### hw/rtl/kplock_core.sv
// ----------------------------------------------------------------------------
// kplock_core
// Entry state, stored code memory, lockout logic and result register.
// ----------------------------------------------------------------------------
module kplock_core #(
    parameter int CODE_LEN = kplock_pkg::CODE_LEN_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  kplock_pkg::cfg_t    cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_func,
    input  logic [7:0]          in_key,
    output logic                out_valid,
    input  logic                out_ready,
    output kplock_pkg::result_t out_res
);
    import kplock_pkg::*;

    localparam int IW = $clog2(CODE_LEN + 1);
    localparam int AW = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
    localparam logic [IW-1:0] LEN_MAX = IW'(CODE_LEN);

    logic [7:0]    code_mem [CODE_LEN];
    logic [7:0]    rd_data_reg;

    logic [IW-1:0] idx_reg, idx_next;
    logic [IW-1:0] len_reg, len_next;
    logic          set_reg, set_next;
    logic          match_reg, match_next;
    logic [7:0]    fail_reg, fail_next;
    logic [7:0]    wait_reg, wait_next;
    logic          blocked_reg, blocked_next;
    logic          relay_reg, relay_next;
    logic          valid_reg;
    result_t       res_reg, res_next;

    logic          acc;
    logic          finish;
    logic          mem_we;
    logic [7:0]    fail_inc;
    event_t        ev;

    assign in_ready = !valid_reg || out_ready;
    assign acc = in_valid && in_ready;
    assign fail_inc = (fail_reg == FAIL_MAX) ? FAIL_MAX : fail_reg + 8'd1;

    always_comb
    begin
        idx_next     = idx_reg;
        len_next     = len_reg;
        set_next     = set_reg;
        match_next   = match_reg;
        fail_next    = fail_reg;
        wait_next    = wait_reg;
        blocked_next = blocked_reg;
        relay_next   = relay_reg;
        mem_we       = 1'b0;
        finish       = 1'b0;
        ev           = EV_NONE;
        if (acc)
        begin
            if (in_func)
            begin
                if (wait_reg != 8'd0)
                    wait_next = wait_reg - 8'd1;
            end
            else if (blocked_reg || wait_reg != 8'd0)
            begin
                ev = EV_NONE;
            end
            else if (relay_reg)
            begin
                relay_next = 1'b0;
            end
            else if (in_key == KEY_CLEAR)
            begin
                idx_next   = '0;
                match_next = 1'b1;
                ev         = EV_CLEARED;
            end
            else
            begin
                if (in_key == KEY_END)
                begin
                    finish = 1'b1;
                end
                else
                begin
                    if (idx_reg < LEN_MAX)
                    begin
                        if (!set_reg)
                            mem_we = 1'b1;
                        else if (idx_reg >= len_reg || rd_data_reg != in_key)
                            match_next = 1'b0;
                        idx_next = idx_reg + IW'(1);
                    end
                    if (idx_next >= LEN_MAX)
                        finish = 1'b1;
                    else
                        ev = EV_TAKEN;
                end
                if (finish)
                begin
                    if (!set_reg)
                    begin
                        len_next = idx_next;
                        set_next = 1'b1;
                        ev       = EV_SAVED;
                    end
                    else if (match_next && idx_next == len_reg)
                    begin
                        relay_next = 1'b1;
                        fail_next  = '0;
                        ev         = EV_CORRECT;
                    end
                    else
                    begin
                        fail_next = fail_inc;
                        ev        = EV_INVALID;
                        if (fail_inc == cfg.block_fail_count)
                        begin
                            blocked_next = 1'b1;
                            ev           = EV_BLOCKED;
                        end
                        else if (fail_inc == cfg.first_fail_count)
                            wait_next = cfg.first_wait;
                        else if (fail_inc == cfg.second_fail_count)
                            wait_next = cfg.second_wait;
                        else if (fail_inc == cfg.third_fail_count)
                            wait_next = cfg.third_wait;
                    end
                    idx_next   = '0;
                    match_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        res_next.relay_open   = relay_next;
        res_next.locked_out   = blocked_next;
        res_next.wait_seconds = wait_next;
        res_next.setup_mode   = !set_next;
        res_next.entry_length = LEN_OUT_W'(idx_next);
        res_next.event_res    = ev;
    end

    // code memory; read is prefetched at the next entry index
    always_ff @(posedge clk)
    begin
        if (mem_we)
            code_mem[idx_reg[AW-1:0]] <= in_key;
        if (idx_next < LEN_MAX)
        begin
            if (mem_we && idx_next == idx_reg)
                rd_data_reg <= in_key;
            else
                rd_data_reg <= code_mem[idx_next[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            len_reg     <= '0;
            set_reg     <= 1'b0;
            match_reg   <= 1'b1;
            fail_reg    <= '0;
            wait_reg    <= '0;
            blocked_reg <= 1'b0;
            relay_reg   <= 1'b0;
            valid_reg   <= 1'b0;
        end
        else
        begin
            idx_reg     <= idx_next;
            len_reg     <= len_next;
            set_reg     <= set_next;
            match_reg   <= match_next;
            fail_reg    <= fail_next;
            wait_reg    <= wait_next;
            blocked_reg <= blocked_next;
            relay_reg   <= relay_next;
            if (acc)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (acc)
            res_reg <= res_next;
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

`ifndef SYNTH
    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= LEN_MAX)
        else $error("entry index beyond code length");

    a_set_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        set_reg |=> set_reg)
        else $error("stored code was dropped");

    a_blocked_closed: assert property (@(posedge clk) disable iff (!rst_n)
        blocked_reg |-> !relay_reg)
        else $error("relay open while blocked");

    a_wait_ignores: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !in_func && wait_reg != 8'd0) |=> (res_reg.event_res == EV_NONE))
        else $error("key acted on during a wait");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && !out_ready) |=> $stable(res_reg))
        else $error("result changed while stalled");
`endif

endmodule
